### src/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

  // Table geometry and time width.
  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 32;
  localparam int MAX_FIRE  = 16;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int FIRE_W = $clog2(MAX_FIRE);

  // Field widths of the stream payloads.
  localparam int ID_W     = 8;
  localparam int FIELD_W  = 32;
  localparam int TARGET_W = 2;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 16;

  localparam logic [63:0] TMAX64 = {64{1'b1}} >> (64 - TIME_BITS);

  typedef logic [TIME_BITS-1:0] tstamp_t;

  typedef enum logic [1:0] {
    OP_REGISTER = 2'd0,
    OP_CANCEL   = 2'd1,
    OP_TICK     = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACK   = 2'd0,
    ST_FIRED = 2'd1,
    ST_NONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_FIRE,
    S_RESP
  } state_t;

  // Saturate an input time field to the largest representable time.
  function automatic tstamp_t clamp_time(logic [FIELD_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > TMAX64) ? TIME_BITS'(TMAX64) : TIME_BITS'(w);
  endfunction

  // Add two times, saturating at the largest representable time.
  function automatic tstamp_t sat_add(tstamp_t a, tstamp_t b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? '1 : s[TIME_BITS-1:0];
  endfunction

endpackage

### src/periodic_timer_scheduler_top.sv
`timescale 1ns / 1ps

// Periodic timer scheduler. Commands arrive on the s_axis stream: tuser holds
// the operation (register, cancel, tick) and tdata the task id, interval, first
// fire time, target and current time. Results leave on the m_axis stream: tuser
// holds the status, tdata the fired id and target, and tlast marks the final
// result of a command.
// The block takes one command at a time; s_axis_tready is high only while idle.
// Every command but unused op code 3 walks the slot table once, one slot per
// cycle, through a single compare and add unit, and then settles its result in
// a decide step. A tick then, for each fired task, updates the slot and emits
// the transfer in a fire step, and makes a new search pass for the earliest due
// slot before each further fired task. Unused op code 3 answers without
// walking the table.
// Results go through one output register. When the receiver stalls, the
// sequencer waits with the next result, and with the slot update of a fired
// task, until that transfer completes.
// Reset (rst, synchronous, active high) empties the table and drops any result
// not yet transferred; slot contents other than the valid bits are left as is.
module periodic_timer_scheduler_top
  import pts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // task_id[7:0], interval[39:8], first_fire[71:40], target[73:72],
  // now_time[105:74], zero fill above.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fired_id[7:0], fired_target[9:8], zero fill above.
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]            m_axis_tuser,
  output logic                  m_axis_tlast
);

  // Slot table. Only the valid bits are reset.
  logic [SLOTS-1:0]    slot_valid;
  logic [ID_W-1:0]     slot_id        [SLOTS];
  tstamp_t             slot_next_fire [SLOTS];
  tstamp_t             slot_interval  [SLOTS];
  logic [TARGET_W-1:0] slot_target    [SLOTS];

  state_t state, state_next;

  // Latched command.
  op_t                 op_r;
  logic [ID_W-1:0]     id_r;
  tstamp_t             ival_r;
  tstamp_t             ff_r;
  logic [TARGET_W-1:0] tg_r;
  tstamp_t             now_r;

  // Scan bookkeeping.
  logic [IDX_W-1:0]  idx;
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;
  logic              have_best;
  logic [IDX_W-1:0]  best_idx;
  tstamp_t           best_nf;
  logic              first_pass;
  logic [SLOTS-1:0]  pending;
  logic [FIRE_W-1:0] fire_cnt;
  status_t           resp_status;

  logic in_xfer;
  logic out_free;
  logic scan_last;

  // Per-slot view of the slot under the scan pointer.
  tstamp_t scan_nf;
  logic    scan_match;
  logic    scan_free;
  logic    scan_due;
  logic    scan_cand;
  logic    scan_better;

  // Shared saturating adder: now plus either the new or the stored interval.
  tstamp_t add_b;
  tstamp_t add_sum;
  logic    last_fire;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign scan_last = (idx == IDX_W'(SLOTS - 1));

  assign scan_nf     = slot_next_fire[idx];
  assign scan_match  = slot_valid[idx] && (slot_id[idx] == id_r);
  assign scan_free   = !slot_valid[idx] || scan_match;
  assign scan_due    = slot_valid[idx] && (scan_nf <= now_r);
  assign scan_cand   = first_pass ? scan_due : pending[idx];
  assign scan_better = scan_cand && (!have_best || (scan_nf < best_nf));

  assign add_b   = (state == S_FIRE) ? slot_interval[best_idx] : ival_r;
  assign add_sum = sat_add(now_r, add_b);

  // The final fired result is the one that empties the due set or reaches the cap.
  assign last_fire = ((pending & ~(SLOTS'(1) << best_idx)) == '0) ||
                     (fire_cnt == FIRE_W'(MAX_FIRE - 1));

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = (op_t'(s_axis_tuser) == OP_NOP) ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = first_pass ? S_DECIDE : S_FIRE;
        end
      end
      S_DECIDE: begin
        state_next = (op_r == OP_TICK && have_best) ? S_FIRE : S_RESP;
      end
      S_FIRE: begin
        if (out_free) begin
          state_next = last_fire ? S_IDLE : S_SCAN;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    s_axis_tready = (state == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command latch and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_pass <= 1'b0;
      have_free  <= 1'b0;
      have_best  <= 1'b0;
      pending    <= '0;
      fire_cnt   <= '0;
      idx        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op_r        <= op_t'(s_axis_tuser);
            id_r        <= s_axis_tdata[7:0];
            ival_r      <= clamp_time(s_axis_tdata[39:8]);
            ff_r        <= clamp_time(s_axis_tdata[71:40]);
            tg_r        <= s_axis_tdata[73:72];
            now_r       <= clamp_time(s_axis_tdata[105:74]);
            idx         <= '0;
            first_pass  <= 1'b1;
            have_free   <= 1'b0;
            have_best   <= 1'b0;
            fire_cnt    <= '0;
            resp_status <= ST_ACK;
          end
        end
        S_SCAN: begin
          idx <= idx + IDX_W'(1);
          if (op_r == OP_REGISTER && scan_free && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= idx;
          end
          if (op_r == OP_TICK) begin
            if (first_pass) begin
              pending[idx] <= scan_due;
            end
            if (scan_better) begin
              have_best <= 1'b1;
              best_idx  <= idx;
              best_nf   <= scan_nf;
            end
          end
        end
        S_DECIDE: begin
          first_pass <= 1'b0;
          if (op_r == OP_REGISTER) begin
            resp_status <= have_free ? ST_ACK : ST_FULL;
          end else if (op_r == OP_TICK) begin
            resp_status <= ST_NONE;
          end else begin
            resp_status <= ST_ACK;
          end
        end
        S_FIRE: begin
          if (out_free) begin
            pending[best_idx] <= 1'b0;
            fire_cnt          <= fire_cnt + FIRE_W'(1);
            have_best         <= 1'b0;
            idx               <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Slot table updates: drop a slot with a matching id during the scan of a
  // register or cancel, insert after it, reschedule or retire a fired slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (state == S_SCAN && first_pass && scan_match &&
          (op_r == OP_REGISTER || op_r == OP_CANCEL)) begin
        slot_valid[idx] <= 1'b0;
      end
      if (state == S_DECIDE && op_r == OP_REGISTER && have_free) begin
        slot_valid[free_idx] <= 1'b1;
      end
      if (state == S_FIRE && out_free && slot_interval[best_idx] == '0) begin
        slot_valid[best_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECIDE && op_r == OP_REGISTER && have_free) begin
      slot_id[free_idx]        <= id_r;
      slot_next_fire[free_idx] <= (ff_r != '0) ? ff_r : add_sum;
      slot_interval[free_idx]  <= ival_r;
      slot_target[free_idx]    <= tg_r;
    end
    if (state == S_FIRE && out_free && slot_interval[best_idx] != '0) begin
      slot_next_fire[best_idx] <= add_sum;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (out_free && state == S_FIRE) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= ST_FIRED;
        m_axis_tdata  <= {{(OUT_DATA_W - ID_W - TARGET_W){1'b0}},
                          slot_target[best_idx], slot_id[best_idx]};
        m_axis_tlast  <= last_fire;
      end else if (out_free && state == S_RESP) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tuser  <= resp_status;
        m_axis_tdata  <= '0;
        m_axis_tlast  <= 1'b1;
      end
    end
  end

endmodule
